@@ rtl/lz10_stream_decompressor_assert.svh @@
// Assertion macros used by the LZ10 decompressor checker.
`ifndef LZ10_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZ10_STREAM_DECOMPRESSOR_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define LZ10_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lz10 assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define LZ10_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("lz10 assertion failed");

`endif

@@ rtl/lz10_pkg.sv @@
// Types and constants shared by the LZ10 stream decompressor modules.
package lz10_pkg;

    localparam logic [7:0] MAGIC_BYTE = 8'h10;
    localparam logic [4:0] MIN_MATCH  = 5'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_end;
        logic       empty_stream;
    } t_out;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_SIZE0,
        PH_SIZE1,
        PH_SIZE2,
        PH_FLAG,
        PH_DATA,
        PH_TOKLO,
        PH_IDLE
    } t_phase;

    typedef enum logic [1:0] {
        S_IN,
        S_DEC,
        S_COPY_RD,
        S_COPY
    } t_state;

    typedef struct packed {
        logic load;
        logic parse;
        logic copy_rd;
        logic copy_step;
    } t_cmd;

    typedef struct packed {
        logic need_slot;
        logic start_copy;
        logic slot_free;
        logic copy_last;
    } t_status;

endpackage

@@ rtl/lz10_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lz10_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ rtl/lz10_ctrl.sv @@
// Sequencer for the LZ10 decompressor: input capture, decode and copy steps.
module lz10_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lz10_pkg::t_status i_status,
    output lz10_pkg::t_cmd    o_cmd
);

    lz10_pkg::t_state r_state;
    lz10_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lz10_pkg::S_IN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            lz10_pkg::S_IN: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lz10_pkg::S_DEC;
                end
            end
            lz10_pkg::S_DEC: begin
                // hold while a result is due and the output slot is busy
                if (!i_status.need_slot || i_status.slot_free) begin
                    o_cmd.parse = 1'b1;
                    n_state     = i_status.start_copy ? lz10_pkg::S_COPY_RD
                                                      : lz10_pkg::S_IN;
                end
            end
            lz10_pkg::S_COPY_RD: begin
                o_cmd.copy_rd = 1'b1;
                n_state       = lz10_pkg::S_COPY;
            end
            lz10_pkg::S_COPY: begin
                if (i_status.slot_free) begin
                    o_cmd.copy_step = 1'b1;
                    if (i_status.copy_last) begin
                        n_state = lz10_pkg::S_IN;
                    end else begin
                        o_cmd.copy_rd = 1'b1;
                    end
                end
            end
            default: begin
                n_state = lz10_pkg::S_IN;
            end
        endcase
    end

endmodule

@@ rtl/lz10_datapath.sv @@
// Header parser, flag tracker, history window and output register for LZ10.
module lz10_datapath #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lz10_pkg::t_in     i_in_item,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output lz10_pkg::t_out    o_out_item,
    input  lz10_pkg::t_cmd    i_cmd,
    output lz10_pkg::t_status o_status
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    // latched input item
    logic [7:0]       r_byte;
    logic             r_start;
    // parse state
    lz10_pkg::t_phase r_phase,      n_phase;
    logic [AW-1:0]    r_wp,         n_wp;
    logic [AW:0]      r_fill,       n_fill;
    logic [7:0]       r_flags,      n_flags;
    logic [3:0]       r_flags_left, n_flags_left;
    logic [23:0]      r_rem,        n_rem;
    logic [7:0]       r_tok_hi,     n_tok_hi;
    // copy engine
    logic [AW-1:0]    r_src,        n_src;
    logic [4:0]       r_count,      n_count;
    logic             r_fwd;
    logic [7:0]       r_fwd_data;
    logic             r_zero;
    // output register
    logic             r_out_valid,  n_out_valid;
    lz10_pkg::t_out   r_out,        n_out;

    lz10_pkg::t_phase eff_phase;
    logic [7:0]       ram_q;
    logic [7:0]       copy_byte;
    logic             we;
    logic [7:0]       wdata;
    logic [23:0]      rem_dec;
    logic [23:0]      size_full;
    logic [4:0]       tok_len;
    logic [12:0]      tok_dist;
    logic             src_written;

    assign eff_phase = r_start ? lz10_pkg::PH_MAGIC : r_phase;
    assign rem_dec   = r_rem - 24'd1;
    assign size_full = {r_byte, r_rem[15:0]};
    assign tok_len   = {1'b0, r_tok_hi[7:4]} + lz10_pkg::MIN_MATCH;
    assign tok_dist  = {1'b0, r_tok_hi[3:0], r_byte} + 13'd1;
    assign copy_byte = r_fwd ? r_fwd_data : (r_zero ? 8'd0 : ram_q);
    // entries are written in order from zero, so the fill count tells which hold data
    assign src_written = r_fill[AW] || (r_src < r_fill[AW-1:0]);

    always_comb begin
        o_status.slot_free  = !r_out_valid || i_out_ready;
        o_status.start_copy = (eff_phase == lz10_pkg::PH_TOKLO);
        o_status.copy_last  = (r_count == 5'd1);
        o_status.need_slot  =
            ((eff_phase == lz10_pkg::PH_MAGIC) && (r_byte != lz10_pkg::MAGIC_BYTE)) ||
            ((eff_phase == lz10_pkg::PH_SIZE2) && (size_full == 24'd0)) ||
            ((eff_phase == lz10_pkg::PH_DATA) && !r_flags[7]);
    end

    always_comb begin
        n_phase      = r_phase;
        n_wp         = r_wp;
        n_fill       = r_fill;
        n_flags      = r_flags;
        n_flags_left = r_flags_left;
        n_rem        = r_rem;
        n_tok_hi     = r_tok_hi;
        n_src        = r_src;
        n_count      = r_count;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        we           = 1'b0;
        wdata        = copy_byte;

        if (i_cmd.parse) begin
            unique case (eff_phase)
                lz10_pkg::PH_MAGIC: begin
                    n_wp         = '0;
                    n_fill       = '0;
                    n_flags      = '0;
                    n_flags_left = '0;
                    n_rem        = '0;
                    n_tok_hi     = '0;
                    if (r_byte == lz10_pkg::MAGIC_BYTE) begin
                        n_phase = lz10_pkg::PH_SIZE0;
                    end else begin
                        n_out       = '{out_byte: 8'd0, last_of_run: 1'b1,
                                        stream_end: 1'b0, empty_stream: 1'b1};
                        n_out_valid = 1'b1;
                        n_phase     = lz10_pkg::PH_IDLE;
                    end
                end
                lz10_pkg::PH_SIZE0: begin
                    n_rem   = {16'd0, r_byte};
                    n_phase = lz10_pkg::PH_SIZE1;
                end
                lz10_pkg::PH_SIZE1: begin
                    n_rem   = {8'd0, r_byte, r_rem[7:0]};
                    n_phase = lz10_pkg::PH_SIZE2;
                end
                lz10_pkg::PH_SIZE2: begin
                    n_rem = size_full;
                    if (size_full == 24'd0) begin
                        n_out       = '{out_byte: 8'd0, last_of_run: 1'b1,
                                        stream_end: 1'b0, empty_stream: 1'b1};
                        n_out_valid = 1'b1;
                        n_phase     = lz10_pkg::PH_IDLE;
                    end else begin
                        n_phase = lz10_pkg::PH_FLAG;
                    end
                end
                lz10_pkg::PH_FLAG: begin
                    n_flags      = r_byte;
                    n_flags_left = 4'd8;
                    n_phase      = lz10_pkg::PH_DATA;
                end
                lz10_pkg::PH_DATA: begin
                    if (r_flags[7]) begin
                        n_tok_hi = r_byte;
                        n_phase  = lz10_pkg::PH_TOKLO;
                    end else begin
                        we          = 1'b1;
                        wdata       = r_byte;
                        n_out       = '{out_byte: r_byte, last_of_run: 1'b1,
                                        stream_end: (rem_dec == 24'd0), empty_stream: 1'b0};
                        n_out_valid = 1'b1;
                    end
                end
                lz10_pkg::PH_TOKLO: begin
                    // clip the copy to what the declared size still allows
                    n_count = (24'(tok_len) > r_rem) ? r_rem[4:0] : tok_len;
                    n_src   = r_wp - AW'(tok_dist);
                end
                lz10_pkg::PH_IDLE: begin
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.copy_step) begin
            we          = 1'b1;
            wdata       = copy_byte;
            n_count     = r_count - 5'd1;
            n_out       = '{out_byte: copy_byte, last_of_run: (r_count == 5'd1),
                            stream_end: (rem_dec == 24'd0), empty_stream: 1'b0};
            n_out_valid = 1'b1;
        end

        if (i_cmd.copy_rd) begin
            n_src = r_src + AW'(1);
        end

        if (we) begin
            n_wp  = r_wp + AW'(1);
            n_rem = rem_dec;
            if (!r_fill[AW]) begin
                n_fill = r_fill + (AW+1)'(1);
            end
            // advance to the next flag bit once the literal or copy is done
            if ((i_cmd.parse || (r_count == 5'd1))) begin
                if (rem_dec == 24'd0) begin
                    n_phase = lz10_pkg::PH_IDLE;
                end else begin
                    n_flags      = {r_flags[6:0], 1'b0};
                    n_flags_left = r_flags_left - 4'd1;
                    n_phase      = (r_flags_left == 4'd1) ? lz10_pkg::PH_FLAG
                                                          : lz10_pkg::PH_DATA;
                end
            end
        end
    end

    lz10_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (wdata),
        .i_re    (i_cmd.copy_rd),
        .i_raddr (r_src),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte  <= i_in_item.in_byte;
            r_start <= i_in_item.stream_start;
        end
        // a read of the entry being written this cycle sees the old data: forward
        if (i_cmd.copy_rd) begin
            r_fwd_data <= wdata;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lz10_pkg::PH_MAGIC;
            r_wp         <= '0;
            r_fill       <= '0;
            r_flags      <= '0;
            r_flags_left <= '0;
            r_rem        <= '0;
            r_tok_hi     <= '0;
            r_src        <= '0;
            r_count      <= '0;
            r_fwd        <= 1'b0;
            r_zero       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_wp         <= n_wp;
            r_fill       <= n_fill;
            r_flags      <= n_flags;
            r_flags_left <= n_flags_left;
            r_rem        <= n_rem;
            r_tok_hi     <= n_tok_hi;
            r_src        <= n_src;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            if (i_cmd.copy_rd) begin
                r_fwd  <= we && (r_src == r_wp);
                r_zero <= !src_written;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ rtl/lz10_stream_decompressor.sv @@
// LZ10 stream decompressor top level: controller plus datapath.
//
//   channel | direction | handshake                  | payload
//   input   | in        | i_in_valid / o_in_ready    | i_in_item  (in_byte, stream_start)
//   output  | out       | o_out_valid / i_out_ready  | o_out_item (out_byte, last_of_run,
//           |           |                            |   stream_end, empty_stream)
//
// Header, flag, literal and back-reference high items go through capture then decode.
// A back-reference low item goes through capture, decode and a first window read, then
// one window read and one window write per copied byte on the two-port history RAM.
// Reset is synchronous; the window reads as zero through a fill count, so no
// clearing pass is needed. A stalled output holds the item and pauses the copy.
module lz10_stream_decompressor #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lz10_pkg::t_in  i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lz10_pkg::t_out o_out_item
);

    lz10_pkg::t_cmd    cmd;
    lz10_pkg::t_status status;

    lz10_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lz10_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

@@ rtl/lz10_checker.sv @@
// Port-level checker for the LZ10 stream decompressor, bound to the top level.
`include "lz10_stream_decompressor_assert.svh"

module lz10_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input lz10_pkg::t_out o_out_item
);

    logic out_stall;
    logic empty_ok;
    logic end_ok;
    logic run_ok;
    logic in_take;

    assign out_stall = o_out_valid && !i_out_ready;
    assign empty_ok  = !(o_out_valid && o_out_item.empty_stream)
                       || (o_out_item.out_byte == 8'd0 && o_out_item.last_of_run
                           && !o_out_item.stream_end);
    assign end_ok    = !(o_out_valid && o_out_item.stream_end) || o_out_item.last_of_run;
    assign run_ok    = !(o_out_valid && !o_out_item.last_of_run) || !o_in_ready;
    assign in_take   = i_in_valid && o_in_ready;

    `LZ10_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_item))
    `LZ10_ASSERT_ALWAYS(a_empty_form, i_clk, i_rst_n, empty_ok)
    `LZ10_ASSERT_ALWAYS(a_end_is_last, i_clk, i_rst_n, end_ok)
    `LZ10_ASSERT_ALWAYS(a_run_blocks_in, i_clk, i_rst_n, run_ok)
    `LZ10_ASSERT_NEXT(a_decode_after_take, i_clk, i_rst_n, in_take, !o_in_ready)

endmodule

bind lz10_stream_decompressor lz10_checker u_checker (.*);

@@ tb/lz10_stream_decompressor_test.sv @@
// Self-checking testbench for the LZ10 stream decompressor: directed headers plus random streams.
module lz10_stream_decompressor_test;

    localparam int WINDOW_DEPTH = 4096;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int ITEM_TARGET  = 150;
    localparam int MAX_REPORTS  = 10;
    localparam int TAIL_CYCLES  = 64;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY} t_rx_mode;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    lz10_pkg::t_in  in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    lz10_pkg::t_out out_item;

    lz10_stream_decompressor #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #4 clk = ~clk;

    // Decoder shadow state
    logic [7:0]       window_mem [0:WINDOW_DEPTH-1];
    logic [11:0]      wr_pos;
    lz10_pkg::t_phase phase;
    logic [7:0]       flags;
    logic [3:0]       flags_left;
    logic [23:0]      remaining;
    logic [7:0]       tok_hi;

    lz10_pkg::t_out pending_out [$];
    lz10_pkg::t_in  stream_q [$];

    int fail_count = 0;
    int results_checked = 0;
    int items_sent = 0;
    int streams_sent = 0;
    int cycle_count = 0;
    int burst_left = 0;

    function automatic void expect_item(input lz10_pkg::t_out r);
        pending_out.insert(pending_out.size(), r);
    endfunction

    function automatic void queue_byte(input lz10_pkg::t_in it);
        stream_q.insert(stream_q.size(), it);
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        window_mem[wr_pos] = b;
        wr_pos = wr_pos + 12'd1;
        remaining = remaining - 24'd1;
        expect_item(lz10_pkg::t_out'{b, 1'b0, (remaining == 24'd0), 1'b0});
    endfunction

    function automatic void advance_flag();
        if (remaining == 24'd0) begin
            phase = lz10_pkg::PH_IDLE;
        end else begin
            flags = flags << 1;
            flags_left = flags_left - 4'd1;
            phase = (flags_left == 4'd0) ? lz10_pkg::PH_FLAG : lz10_pkg::PH_DATA;
        end
    endfunction

    // Work out every decompressed byte caused by one accepted item.
    function automatic void decode_item(input lz10_pkg::t_in it);
        int             made;
        logic [4:0]     copy_len;
        logic [12:0]    distance;
        logic [11:0]    src;
        lz10_pkg::t_out r;
        made = pending_out.size();
        if (it.stream_start) begin
            phase = lz10_pkg::PH_MAGIC;
        end
        case (phase)
            lz10_pkg::PH_MAGIC: begin
                for (int i = 0; i < WINDOW_DEPTH; i++) begin
                    window_mem[i] = 8'h00;
                end
                wr_pos = '0;
                flags = '0;
                flags_left = '0;
                remaining = '0;
                tok_hi = '0;
                if (it.in_byte == lz10_pkg::MAGIC_BYTE) begin
                    phase = lz10_pkg::PH_SIZE0;
                end else begin
                    expect_item(lz10_pkg::t_out'{8'h00, 1'b0, 1'b0, 1'b1});
                    phase = lz10_pkg::PH_IDLE;
                end
            end
            lz10_pkg::PH_SIZE0: begin
                remaining = {16'h0000, it.in_byte};
                phase = lz10_pkg::PH_SIZE1;
            end
            lz10_pkg::PH_SIZE1: begin
                remaining[15:8] = it.in_byte;
                phase = lz10_pkg::PH_SIZE2;
            end
            lz10_pkg::PH_SIZE2: begin
                remaining[23:16] = it.in_byte;
                if (remaining == 24'd0) begin
                    expect_item(lz10_pkg::t_out'{8'h00, 1'b0, 1'b0, 1'b1});
                    phase = lz10_pkg::PH_IDLE;
                end else begin
                    phase = lz10_pkg::PH_FLAG;
                end
            end
            lz10_pkg::PH_FLAG: begin
                flags = it.in_byte;
                flags_left = 4'd8;
                phase = lz10_pkg::PH_DATA;
            end
            lz10_pkg::PH_DATA: begin
                if (flags[7]) begin
                    tok_hi = it.in_byte;
                    phase = lz10_pkg::PH_TOKLO;
                end else begin
                    push_byte(it.in_byte);
                    advance_flag();
                end
            end
            lz10_pkg::PH_TOKLO: begin
                copy_len = {1'b0, tok_hi[7:4]} + lz10_pkg::MIN_MATCH;
                distance = {1'b0, tok_hi[3:0], it.in_byte} + 13'd1;
                src = wr_pos - distance[11:0];
                // clip the copy to the declared size
                if (copy_len > remaining) begin
                    copy_len = remaining[4:0];
                end
                for (int i = 0; i < copy_len; i++) begin
                    push_byte(window_mem[src]);
                    src = src + 12'd1;
                end
                advance_flag();
            end
            default: begin
            end
        endcase
        if (pending_out.size() > made) begin
            r = pending_out[$];
            r.last_of_run = 1'b1;
            pending_out[pending_out.size() - 1] = r;
        end
    endfunction

    function automatic void note_failure(input string msg);
        if (fail_count < MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
        fail_count++;
    endfunction

    // Send one item in bursts with random gaps; called at a rising edge.
    task automatic send_item(input logic [7:0] b, input logic start);
        int gap;
        in_valid <= 1'b1;
        in_item <= lz10_pkg::t_in'{b, start};
        do @(posedge clk); while (!in_ready);
        decode_item(lz10_pkg::t_in'{b, start});
        items_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Hold the sender until every expected byte has come out.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_out.size() != 0);
    endtask

    task automatic build_stream(input logic [23:0] declared, input int body_limit);
        int         made;
        int         distance;
        logic [7:0] flag_byte;
        logic [3:0] len_code;
        stream_q.delete();
        queue_byte(lz10_pkg::t_in'{lz10_pkg::MAGIC_BYTE, 1'b1});
        queue_byte(lz10_pkg::t_in'{declared[7:0], 1'b0});
        queue_byte(lz10_pkg::t_in'{declared[15:8], 1'b0});
        queue_byte(lz10_pkg::t_in'{declared[23:16], 1'b0});
        made = 0;
        while (made < declared && stream_q.size() < body_limit) begin
            flag_byte = 8'($urandom_range(0, 255));
            queue_byte(lz10_pkg::t_in'{flag_byte, 1'b0});
            for (int k = 7; k >= 0 && made < declared; k--) begin
                if (flag_byte[k]) begin
                    len_code = 4'($urandom_range(0, 15));
                    // mostly short distances into written history, some anywhere
                    if (made > 0 && $urandom_range(0, 3) != 0) begin
                        distance = $urandom_range(0, (made > 32) ? 31 : made - 1);
                    end else begin
                        distance = $urandom_range(0, WINDOW_DEPTH - 1);
                    end
                    queue_byte(lz10_pkg::t_in'{{len_code, distance[11:8]}, 1'b0});
                    queue_byte(lz10_pkg::t_in'{distance[7:0], 1'b0});
                    made += len_code + 3;
                end else begin
                    queue_byte(lz10_pkg::t_in'{8'($urandom_range(0, 255)), 1'b0});
                    made++;
                end
            end
        end
    endtask

    task automatic test_start_without_flag();
        // magic taken without stream_start, literal then a clipped run copy
        send_item(8'h10, 1'b0);
        send_item(8'h04, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h40, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hF0, 1'b0);
        send_item(8'h00, 1'b0);
        drain_outputs();
        streams_sent++;
    endtask

    task automatic test_bad_magic();
        send_item(8'hEF, 1'b1);
        send_item(8'hFF, 1'b0);
        streams_sent++;
    endtask

    task automatic test_zero_size();
        send_item(8'h10, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        streams_sent++;
    endtask

    task automatic test_restart_mid_stream();
        // maximum size, a copy from the full distance of never-written history
        send_item(8'h10, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h0F, 1'b0);
        send_item(8'hFF, 1'b0);
        // abandon it and finish a short stream, then feed a byte past the end
        send_item(8'h10, 1'b1);
        send_item(8'h02, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b0);
        send_item(8'h33, 1'b0);
        streams_sent += 2;
    endtask

    task automatic test_random_streams();
        int          pick;
        int          extra;
        logic [7:0]  b;
        logic [23:0] declared;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                declared = ($urandom_range(0, 14) == 0) ? 24'($urandom_range(49, 200))
                                                        : 24'($urandom_range(1, 48));
                build_stream(declared, 1 << 20);
                extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
                repeat (extra) queue_byte(lz10_pkg::t_in'{8'($urandom_range(0, 255)), 1'b0});
            end else if (pick < 82) begin
                build_stream(24'($urandom_range(1, 24'hFFFFFF)), $urandom_range(4, 20));
            end else if (pick < 88) begin
                b = 8'($urandom_range(0, 254));
                if (b >= lz10_pkg::MAGIC_BYTE) begin
                    b = b + 8'd1;
                end
                stream_q.delete();
                queue_byte(lz10_pkg::t_in'{b, 1'b1});
            end else if (pick < 93) begin
                build_stream(24'd0, 4);
            end else begin
                stream_q.delete();
                repeat ($urandom_range(1, 6)) begin
                    queue_byte(lz10_pkg::t_in'{8'($urandom_range(0, 255)),
                                               ($urandom_range(0, 3) == 0)});
                end
            end
            foreach (stream_q[i]) begin
                send_item(stream_q[i].in_byte, stream_q[i].stream_start);
            end
            streams_sent++;
            if ($urandom_range(0, 11) == 0) begin
                drain_outputs();
            end
        end
    endtask

    // Receiver stall pattern: open, random, or long bursty stalls
    t_rx_mode rx_mode = RX_OPEN;
    int rx_mode_left = 0;
    int rx_hold_left = 0;

    always @(posedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(50, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN: begin
                out_ready <= 1'b1;
            end
            RX_RANDOM: begin
                out_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (rx_hold_left == 0) begin
                    out_ready <= ~out_ready;
                    rx_hold_left <= out_ready ? $urandom_range(1, 20) : $urandom_range(1, 6);
                end else begin
                    rx_hold_left <= rx_hold_left - 1;
                end
            end
        endcase
    end

    always @(posedge clk) begin
        lz10_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_out.size() == 0) begin
                note_failure($sformatf("unexpected item: byte %02h last %0b end %0b empty %0b",
                    out_item.out_byte, out_item.last_of_run, out_item.stream_end,
                    out_item.empty_stream));
            end else begin
                want = pending_out.pop_front();
                results_checked++;
                if (out_item.out_byte !== want.out_byte
                        || out_item.last_of_run !== want.last_of_run
                        || out_item.stream_end !== want.stream_end
                        || out_item.empty_stream !== want.empty_stream) begin
                    note_failure($sformatf(
                        "item %0d: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                        results_checked, want.out_byte, want.last_of_run, want.stream_end,
                        want.empty_stream, out_item.out_byte, out_item.last_of_run,
                        out_item.stream_end, out_item.empty_stream));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        wr_pos = '0;
        phase = lz10_pkg::PH_MAGIC;
        flags = '0;
        flags_left = '0;
        remaining = '0;
        tok_hi = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_mem[i] = 8'h00;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_start_without_flag();
        test_bad_magic();
        test_zero_size();
        test_restart_mid_stream();
        test_random_streams();

        in_valid <= 1'b0;
        do @(posedge clk); while (pending_out.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_out.size() != 0) begin
            note_failure($sformatf("%0d expected items never came out", pending_out.size()));
        end

        $display("Sent %0d items in %0d streams, checked %0d decompressed items",
                 items_sent, streams_sent, results_checked);
        $display("Covered header rejection, restarts, clipped and overlapping copies; %0d errors",
                 fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
